>>> design/assert_macros.svh
// assertion helpers, clock and reset names are fixed by the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> design/geb_pkg.sv
`default_nettype none
package geb_pkg;

    localparam int NUM_BTN   = 16;
    localparam int NUM_STICK = 4;
    localparam int STK_W     = 5;

    localparam logic [1:0] REQ_CMD    = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] CMD_BTN_EN = 2'd0;
    localparam logic [1:0] CMD_STICKS = 2'd1;
    localparam logic [1:0] CMD_PERIOD = 2'd2;

    localparam logic [7:0]  BYTE_NO_BTN   = 8'h80;
    localparam logic [3:0]  BTN_PREFIX    = 4'hF;
    localparam logic [15:0] FORCED_PREV   = 16'h00FF;
    localparam logic [15:0] MASK_RESET    = 16'hFFFF;
    localparam logic [5:0]  PERIOD_RESET  = 6'd15;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  cmd_byte;
        logic [15:0] button_bits;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
    } t_out_word;

    // one sample's worth of pending event bytes
    typedef struct packed {
        logic                              btn_zero;
        logic [NUM_BTN-1:0]                btn_mask;
        logic [NUM_STICK-1:0]              stk_mask;
        logic [NUM_STICK-1:0][STK_W-1:0]   stk_val;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic valid;
    } t_q_ctrl;

endpackage
`default_nettype wire

>>> design/geb_front.sv
`default_nettype none
module geb_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire geb_pkg::t_in_word i_data,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output geb_pkg::t_job         o_job
);
    import geb_pkg::*;

    logic [15:0] r_enable_mask, n_enable_mask;
    logic        r_sticks_on,   n_sticks_on;
    logic [5:0]  r_period_code, n_period_code;
    logic        r_poll_on,     n_poll_on;
    logic [15:0] r_idle_count,  n_idle_count;
    logic [15:0] r_prev_btn,    n_prev_btn;
    logic [NUM_STICK-1:0][STK_W-1:0] r_prev_stk, n_prev_stk;

    logic                            accept;
    logic [15:0]                     masked;
    logic                            btn_chg;
    logic [NUM_STICK-1:0][STK_W-1:0] stk_now;
    logic [NUM_STICK-1:0]            stk_chg;
    logic [15:0]                     tick_count;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign masked     = i_data.button_bits & r_enable_mask;
    assign btn_chg    = masked != r_prev_btn;
    assign stk_now[0] = i_data.left_x[7:3];
    assign stk_now[1] = i_data.left_y[7:3];
    assign stk_now[2] = i_data.right_x[7:3];
    assign stk_now[3] = i_data.right_y[7:3];
    assign tick_count = r_idle_count + 16'd1;

    always_comb begin
        for (int k = 0; k < NUM_STICK; k++) begin
            stk_chg[k] = r_sticks_on && (stk_now[k] != r_prev_stk[k]);
        end
    end

    always_comb begin
        o_job.btn_zero = btn_chg && (masked == '0);
        o_job.btn_mask = btn_chg ? masked : '0;
        o_job.stk_mask = stk_chg;
        o_job.stk_val  = stk_now;
        o_push = accept && (i_data.req_type == REQ_SAMPLE) && (btn_chg || (|stk_chg));
    end

    always_comb begin
        n_enable_mask = r_enable_mask;
        n_sticks_on   = r_sticks_on;
        n_period_code = r_period_code;
        n_poll_on     = r_poll_on;
        n_idle_count  = r_idle_count;
        n_prev_btn    = r_prev_btn;
        n_prev_stk    = r_prev_stk;
        if (accept) begin
            case (i_data.req_type)
                REQ_CMD: begin
                    case (i_data.cmd_byte[7:6])
                        CMD_BTN_EN: begin
                            if (!i_data.cmd_byte[5]) begin
                                n_enable_mask[i_data.cmd_byte[4:1]] = i_data.cmd_byte[0];
                            end
                        end
                        CMD_STICKS: begin
                            n_sticks_on = i_data.cmd_byte[0];
                        end
                        CMD_PERIOD: begin
                            n_period_code = i_data.cmd_byte[5:0];
                            n_poll_on     = i_data.cmd_byte[5:0] != '0;
                        end
                        default: begin
                        end
                    endcase
                end
                REQ_SAMPLE: begin
                    if (btn_chg) begin
                        n_prev_btn   = masked;
                        n_idle_count = '0;
                    end
                    for (int k = 0; k < NUM_STICK; k++) begin
                        if (stk_chg[k]) begin
                            n_prev_stk[k] = stk_now[k];
                        end
                    end
                end
                REQ_TICK: begin
                    n_idle_count = tick_count;
                    // count keeps running after the forced resend
                    if (r_poll_on && (tick_count == {2'b00, r_period_code, 8'h00})) begin
                        n_prev_btn = FORCED_PREV;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= MASK_RESET;
            r_sticks_on   <= 1'b0;
            r_period_code <= PERIOD_RESET;
            r_poll_on     <= 1'b1;
            r_idle_count  <= '0;
            r_prev_btn    <= '0;
            r_prev_stk    <= '0;
        end else begin
            r_enable_mask <= n_enable_mask;
            r_sticks_on   <= n_sticks_on;
            r_period_code <= n_period_code;
            r_poll_on     <= n_poll_on;
            r_idle_count  <= n_idle_count;
            r_prev_btn    <= n_prev_btn;
            r_prev_stk    <= n_prev_stk;
        end
    end

endmodule
`default_nettype wire

>>> design/geb_queue.sv
`default_nettype none
module geb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire geb_pkg::t_job i_job,
    input  wire logic          i_pop,
    output geb_pkg::t_q_ctrl   o_stat,
    output geb_pkg::t_job      o_job
);
    import geb_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       do_push;
    logic       do_pop;

    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    always_comb begin
        o_stat.push  = do_push;
        o_stat.pop   = do_pop;
        o_stat.full  = r_count == 2'd2;
        o_stat.valid = r_count != 2'd0;
        o_job        = r_mem[r_rd_ptr];
        n_wr_ptr     = r_wr_ptr ^ do_push;
        n_rd_ptr     = r_rd_ptr ^ do_pop;
        n_count      = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> design/geb_back.sv
`default_nettype none
module geb_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire geb_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_valid,
    input  wire logic          i_ready,
    output geb_pkg::t_out_word o_data
);
    import geb_pkg::*;

    logic                 r_busy,    n_busy;
    t_job                 r_job,     n_job;
    logic                 r_valid,   n_valid;
    t_out_word            r_out,     n_out;

    logic                 emit;
    logic [3:0]           btn_idx;
    logic [1:0]           stk_idx;
    logic [NUM_BTN-1:0]   btn_rest;
    logic [NUM_STICK-1:0] stk_rest;
    logic                 rest_zero;
    logic                 rest_btn_zero;
    logic [7:0]           next_byte;

    assign emit  = r_busy && (!r_valid || i_ready);
    assign o_pop = !r_busy && i_q_valid;

    // lowest pending button and stick
    always_comb begin
        btn_idx = '0;
        for (int b = NUM_BTN - 1; b >= 0; b--) begin
            if (r_job.btn_mask[b]) begin
                btn_idx = 4'(b);
            end
        end
        stk_idx = '0;
        for (int k = NUM_STICK - 1; k >= 0; k--) begin
            if (r_job.stk_mask[k]) begin
                stk_idx = 2'(k);
            end
        end
    end

    always_comb begin
        btn_rest      = r_job.btn_mask;
        stk_rest      = r_job.stk_mask;
        rest_btn_zero = 1'b0;
        if (r_job.btn_zero) begin
            next_byte = BYTE_NO_BTN;
        end else if (r_job.btn_mask != '0) begin
            next_byte = {BTN_PREFIX, btn_idx};
            btn_rest  = r_job.btn_mask & (r_job.btn_mask - 16'd1);
        end else begin
            next_byte = {1'b0, stk_idx, r_job.stk_val[stk_idx]};
            stk_rest[stk_idx] = 1'b0;
        end
        rest_zero = !rest_btn_zero && (btn_rest == '0) && (stk_rest == '0);
    end

    always_comb begin
        n_busy  = r_busy;
        n_job   = r_job;
        n_valid = r_valid;
        n_out   = r_out;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
        end else if (emit) begin
            n_valid             = 1'b1;
            n_out.tx_byte       = next_byte;
            n_out.last_of_run   = rest_zero;
            n_job.btn_zero      = rest_btn_zero;
            n_job.btn_mask      = btn_rest;
            n_job.stk_mask      = stk_rest;
            n_busy              = !rest_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

>>> design/gamepad_event_byte_encoder.sv
// Gamepad event byte encoder. Commands and idle ticks take effect in the
// cycle they are accepted and emit nothing. A sample whose enabled buttons or
// enabled stick values changed becomes a job in a two-deep queue; the back end
// then sends one byte per cycle (0x80 or 0xF0|button for each pressed button,
// then changed sticks LX, LY, RX, RY as 0x00/0x20/0x40/0x60 | top 5 bits),
// flagging the last byte of the sample with last_of_run and pausing while the
// output is stalled. A job is loaded, then sent (at most 20 bytes), before the
// next is taken; input is held off only while the queue is full.
`default_nettype none
`include "assert_macros.svh"
module gamepad_event_byte_encoder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire geb_pkg::t_in_word i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output geb_pkg::t_out_word     o_data
);
    import geb_pkg::*;

    t_job    fr_job;
    t_job    q_job;
    logic    fr_push;
    logic    bk_pop;
    logic    bk_busy;
    t_q_ctrl q_stat;

    geb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_stat.full),
        .o_push   (fr_push),
        .o_job    (fr_job)
    );

    geb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_job   (fr_job),
        .i_pop   (bk_pop),
        .o_stat  (q_stat),
        .o_job   (q_job)
    );

    geb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_stat.valid),
        .i_job     (q_job),
        .o_pop     (bk_pop),
        .o_busy    (bk_busy),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    // a job is never dropped by the queue
    `ASSERT_NEVER(a_push_lost, fr_push && !q_stat.push)
    // a waiting byte that is not the last means the back end still has work
    `ASSERT_NEVER(a_run_cut, o_valid && !o_data.last_of_run && !bk_busy)
    // a popped job keeps the back end busy next cycle
    `ASSERT_CLK(a_pop_load, q_stat.pop |=> bk_busy)

endmodule
`default_nettype wire

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import geb_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CMD_RSVD   = 2'd3;
    localparam int         LIMIT      = 2_000_000;

    typedef enum {BY_MODEL, NO_BYTES, ONE_BYTE} t_row_chk;

    typedef struct {
        t_in_word   w;
        t_row_chk   chk;
        logic [7:0] tx;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    gamepad_event_byte_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // encoder state as the bench sees it
    logic [15:0] en_mask;
    logic        sticks_on;
    logic [5:0]  period_code;
    logic        poll_on;
    logic [15:0] idle_count;
    logic [15:0] prev_btn;
    logic [4:0]  prev_stk [4];

    // last raw sample sent, used to build repeats and small moves
    logic [15:0] last_btn = '0;
    logic [7:0]  last_stk [4] = '{default: '0};

    t_out_word tx_expect [$];
    t_row      dir_rows [$];
    int        errors = 0;
    int        cycles = 0;
    int        stall_left = 0;
    bit        rx_calm = 0;
    bit        tx_calm = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        if (errors <= 40)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic void encoder_reset();
        en_mask     = MASK_RESET;
        sticks_on   = 1'b0;
        period_code = PERIOD_RESET;
        poll_on     = 1'b1;
        idle_count  = '0;
        prev_btn    = '0;
        foreach (prev_stk[k])
            prev_stk[k] = '0;
    endfunction

    // applies one word to the bench state, queues the bytes it should cause
    function automatic void predict_bytes(input t_in_word w, input bit keep);
        t_out_word   run [$];
        logic [15:0] btn;
        logic [4:0]  v;
        logic [7:0]  stk [4];
        stk = '{w.left_x, w.left_y, w.right_x, w.right_y};
        case (w.req_type)
            REQ_CMD: begin
                case (w.cmd_byte[7:6])
                    CMD_BTN_EN: begin
                        if (!w.cmd_byte[5])
                            en_mask[w.cmd_byte[4:1]] = w.cmd_byte[0];
                    end
                    CMD_STICKS: sticks_on = w.cmd_byte[0];
                    CMD_PERIOD: begin
                        period_code = w.cmd_byte[5:0];
                        poll_on     = (period_code != 6'd0);
                    end
                    default: ;
                endcase
            end
            REQ_TICK: begin
                idle_count = idle_count + 16'd1;
                if (poll_on && idle_count == {2'b00, period_code, 8'h00})
                    prev_btn = FORCED_PREV;
            end
            REQ_SAMPLE: begin
                btn = w.button_bits & en_mask;
                if (btn != prev_btn) begin
                    prev_btn   = btn;
                    idle_count = '0;
                    if (btn == '0)
                        run.push_back('{tx_byte: BYTE_NO_BTN, last_of_run: 1'b0});
                    else
                        for (int i = 0; i < NUM_BTN; i++)
                            if (btn[i])
                                run.push_back('{tx_byte: {BTN_PREFIX, 4'(i)},
                                                last_of_run: 1'b0});
                end
                if (sticks_on)
                    for (int k = 0; k < NUM_STICK; k++) begin
                        v = stk[k][7:3];
                        if (v != prev_stk[k]) begin
                            prev_stk[k] = v;
                            run.push_back('{tx_byte: {1'b0, 2'(k), v}, last_of_run: 1'b0});
                        end
                    end
            end
            default: ;
        endcase
        if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
        if (keep)
            foreach (run[i])
                tx_expect.push_back(run[i]);
    endfunction

    function automatic t_in_word w_cmd(input logic [7:0] c);
        t_in_word w;
        w          = '0;
        w.req_type = REQ_CMD;
        w.cmd_byte = c;
        return w;
    endfunction

    function automatic t_in_word w_smp(input logic [15:0] btn, input logic [7:0] lx,
                                       input logic [7:0] ly, input logic [7:0] rx,
                                       input logic [7:0] ry);
        t_in_word w;
        w             = '0;
        w.req_type    = REQ_SAMPLE;
        w.button_bits = btn;
        w.left_x      = lx;
        w.left_y      = ly;
        w.right_x     = rx;
        w.right_y     = ry;
        return w;
    endfunction

    function automatic t_in_word w_tick();
        t_in_word w;
        w          = '0;
        w.req_type = REQ_TICK;
        return w;
    endfunction

    function automatic void add_row(input t_in_word w, input t_row_chk c,
                                    input logic [7:0] tx);
        dir_rows.push_back('{w: w, chk: c, tx: tx});
    endfunction

    function automatic int gap_len();
        int r;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [7:0] rand_cmd();
        int c;
        c = $urandom_range(0, 19);
        if (c < 7)
            return {CMD_BTN_EN, 1'($urandom_range(0, 9) == 0), 4'($urandom_range(0, 15)),
                    1'($urandom_range(0, 9) < 6)};
        if (c < 13)
            return {CMD_STICKS, 5'($urandom), 1'($urandom_range(0, 9) < 7)};
        if (c < 17)
            return {CMD_PERIOD, ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom)};
        return {CMD_RSVD, 6'($urandom)};
    endfunction

    function automatic t_in_word rand_word();
        t_in_word   w;
        logic [7:0] s [4];
        int         r;
        int         c;
        w.cmd_byte    = 8'($urandom);
        w.button_bits = 16'($urandom);
        foreach (s[k])
            s[k] = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 60) begin
            w.req_type = REQ_SAMPLE;
            c = $urandom_range(0, 19);
            if (c < 5)
                w.button_bits = last_btn;
            else if (c < 8)
                w.button_bits = 16'd1 << $urandom_range(0, 15);
            else if (c < 10)
                w.button_bits = '0;
            else if (c < 11)
                w.button_bits = 16'hFFFF;
            foreach (s[k]) begin
                c = $urandom_range(0, 19);
                if (c < 8)
                    s[k] = last_stk[k];
                else if (c < 11)
                    s[k] = last_stk[k] ^ 8'($urandom_range(0, 7));
            end
        end else if (r < 80) begin
            w.req_type = REQ_CMD;
            w.cmd_byte = rand_cmd();
        end else if (r < 94) begin
            w.req_type = REQ_TICK;
        end else begin
            w.req_type = REQ_UNUSED;
        end
        w.left_x  = s[0];
        w.left_y  = s[1];
        w.right_x = s[2];
        w.right_y = s[3];
        return w;
    endfunction

    // holds the word until accepted; valid is left high for the caller
    task automatic drive_word(input t_in_word w, input bit gaps, input bit keep);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        predict_bytes(w, keep);
        if (w.req_type == REQ_SAMPLE) begin
            last_btn = w.button_bits;
            last_stk = '{w.left_x, w.left_y, w.right_x, w.right_y};
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tx_expect.size() != 0);
    endtask

    // shortest period, then enough ticks to force the previous button word
    task automatic idle_burst(input int n);
        drive_word(w_cmd({CMD_PERIOD, 6'd1}), 1, 1);
        drive_word(w_cmd({CMD_BTN_EN, 1'b0, 4'd0, 1'b1}), 1, 1);
        drive_word(w_smp(prev_btn ^ 16'h0001, last_stk[0], last_stk[1], last_stk[2],
                         last_stk[3]), 1, 1);
        repeat (n) drive_word(w_tick(), 0, 1);
        drive_word(w_smp(last_btn, last_stk[0], last_stk[1], last_stk[2], last_stk[3]),
                   1, 1);
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 499) == 0)
            rx_calm = !rx_calm;
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(8, 40);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (tx_expect.size() == 0) begin
                report($sformatf("unexpected byte %h last %b", o_data.tx_byte,
                                 o_data.last_of_run));
            end else begin
                want = tx_expect.pop_front();
                if (o_data.tx_byte !== want.tx_byte)
                    report($sformatf("tx_byte %h, want %h", o_data.tx_byte, want.tx_byte));
                if (o_data.last_of_run !== want.last_of_run)
                    report($sformatf("last_of_run %b, want %b on byte %h",
                                     o_data.last_of_run, want.last_of_run, want.tx_byte));
            end
        end
    end

    initial begin
        t_in_word junk;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        i_ready <= 1'b0;
        encoder_reset();

        junk = '{req_type: REQ_UNUSED, cmd_byte: 8'h55, button_bits: 16'hFFFF,
                 left_x: 8'hFF, left_y: 8'hAA, right_x: 8'h55, right_y: 8'h00};

        add_row(w_smp(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00), NO_BYTES, 8'h00);
        add_row(w_smp(16'h0001, 8'h00, 8'h00, 8'h00, 8'h00), ONE_BYTE, {BTN_PREFIX, 4'd0});
        add_row(w_smp(16'h8000, 8'h00, 8'h00, 8'h00, 8'h00), ONE_BYTE, {BTN_PREFIX, 4'd15});
        add_row(w_smp(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00), ONE_BYTE, BYTE_NO_BTN);
        add_row(w_smp(16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00), BY_MODEL, 8'h00);
        add_row(w_cmd({CMD_BTN_EN, 1'b0, 4'd0, 1'b0}), NO_BYTES, 8'h00);
        // bit 5 set: must not touch button 15
        add_row(w_cmd({CMD_BTN_EN, 1'b1, 4'd15, 1'b0}), NO_BYTES, 8'h00);
        add_row(w_smp(16'h0001, 8'h00, 8'h00, 8'h00, 8'h00), ONE_BYTE, BYTE_NO_BTN);
        add_row(w_cmd({CMD_BTN_EN, 1'b0, 4'd0, 1'b1}), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_BTN_EN, 1'b0, 4'd15, 1'b0}), NO_BYTES, 8'h00);
        add_row(w_smp(16'h8000, 8'h00, 8'h00, 8'h00, 8'h00), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_BTN_EN, 1'b0, 4'd15, 1'b1}), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_STICKS, 6'd1}), NO_BYTES, 8'h00);
        add_row(w_smp(16'h8000, 8'hFF, 8'h00, 8'h80, 8'h07), BY_MODEL, 8'h00);
        add_row(w_smp(16'h8000, 8'hFF, 8'hFF, 8'hFF, 8'hFF), BY_MODEL, 8'h00);
        add_row(w_smp(16'h8000, 8'hFF, 8'hFF, 8'hFF, 8'hFF), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_STICKS, 6'd0}), NO_BYTES, 8'h00);
        // sticks off: old stick values kept, nothing sent
        add_row(w_smp(16'h8000, 8'h00, 8'h00, 8'h00, 8'h00), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_RSVD, 6'h00}), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_RSVD, 6'h3F}), NO_BYTES, 8'h00);
        add_row(junk, NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_PERIOD, 6'd1}), NO_BYTES, 8'h00);
        add_row(w_tick(), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_PERIOD, 6'h3F}), NO_BYTES, 8'h00);
        add_row(w_cmd({CMD_PERIOD, 6'd0}), NO_BYTES, 8'h00);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            drive_word(dir_rows[i].w, 1, dir_rows[i].chk == BY_MODEL);
            if (dir_rows[i].chk == ONE_BYTE)
                tx_expect.push_back('{tx_byte: dir_rows[i].tx, last_of_run: 1'b1});
        end
        wait_drained();

        for (int k = 0; k < 100; k++) begin
            if (k % 25 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (k == 40)
                idle_burst(256 + $urandom_range(0, 8));
            if (k == 70)
                wait_drained();
            drive_word(rand_word(), 1, 1);
        end
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (errors == 0 && tx_expect.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
